[hdl/pesc_pkg.sv]
// Shared types, constants and helper functions for the printable escape encoder.
package pesc_pkg;

    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_DEL    = 8'h7F;
    localparam logic [7:0] CTRL_MAX    = 8'h1F;

    localparam int CMD_BYTES   = 4;
    localparam int CMD_CNT_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_TAB = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_LF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 2'd3;

    typedef enum logic [1:0] {
        SCAN_IDLE   = 2'd0,
        SCAN_BSLASH = 2'd1,
        SCAN_HELD   = 2'd2
    } scan_t;

    typedef struct packed {
        logic tab;
        logic lf;
        logic cr;
    } esc_cfg_t;

    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] bytes;
        logic [CMD_CNT_W-1:0]      count;
        logic                      status;
    } cmd_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
        begin
            r = 8'h30 + {4'd0, nib};
        end
        else
        begin
            r = 8'h37 + {4'd0, nib};
        end
        return r;
    endfunction

    function automatic logic is_upper_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

endpackage

[hdl/pesc_front.sv]
// Front end: tracks the backslash scan state and turns items into byte commands.
module pesc_front
    import pesc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  esc_cfg_t   esc_cfg,
    output cmd_t       cmd,
    output logic       cmd_push
);

    scan_t      mode_reg;
    scan_t      mode_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= SCAN_IDLE;
            held_reg <= 8'd0;
        end
        else
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
        end
    end

    always_comb
    begin
        logic                      after_bs;
        logic                      do_plain;
        logic                      esc;
        logic [CMD_CNT_W-1:0]      n;
        logic [CMD_BYTES-1:0][7:0] b;
        scan_t                     m;
        logic [7:0]                h;

        n        = '0;
        b        = '0;
        m        = mode_reg;
        h        = held_reg;
        after_bs = (mode_reg == SCAN_BSLASH);
        do_plain = 1'b1;

        if (in_byte >= CHAR_DEL)
        begin
            esc = 1'b1;
        end
        else if (in_byte > CTRL_MAX)
        begin
            esc = 1'b0;
        end
        else if (in_byte == CHAR_TAB)
        begin
            esc = esc_cfg.tab;
        end
        else if (in_byte == CHAR_LF)
        begin
            esc = esc_cfg.lf;
        end
        else if (in_byte == CHAR_CR)
        begin
            esc = esc_cfg.cr;
        end
        else
        begin
            esc = 1'b1;
        end

        if (mode_reg == SCAN_HELD)
        begin
            if (is_upper_hex(in_byte))
            begin
                b[0]     = CHAR_DOT;
                b[1]     = held_reg;
                b[2]     = in_byte;
                n        = 3'd3;
                m        = SCAN_IDLE;
                do_plain = 1'b0;
            end
            else
            begin
                b[0]     = held_reg;
                n        = 3'd1;
                m        = SCAN_IDLE;
                after_bs = 1'b0;
            end
            h = 8'd0;
        end

        if (do_plain)
        begin
            if (esc)
            begin
                b[n[1:0]] = CHAR_BSLASH;
                n         = n + 3'd1;
                b[n[1:0]] = hex_char(in_byte[7:4]);
                n         = n + 3'd1;
                b[n[1:0]] = hex_char(in_byte[3:0]);
                n         = n + 3'd1;
                m         = SCAN_IDLE;
            end
            else if (in_byte == CHAR_BSLASH)
            begin
                b[n[1:0]] = in_byte;
                n         = n + 3'd1;
                m         = SCAN_BSLASH;
            end
            else if (after_bs && (in_byte == CHAR_DOT))
            begin
                b[n[1:0]] = in_byte;
                n         = n + 3'd1;
                m         = SCAN_BSLASH;
            end
            else if (after_bs && is_upper_hex(in_byte))
            begin
                h = in_byte;
                m = SCAN_HELD;
            end
            else
            begin
                b[n[1:0]] = in_byte;
                n         = n + 3'd1;
                m         = SCAN_IDLE;
            end
        end

        if (in_last)
        begin
            if (m == SCAN_HELD)
            begin
                b[n[1:0]] = h;
                n         = n + 3'd1;
            end
            m = SCAN_IDLE;
            h = 8'd0;
        end

        cmd.bytes  = b;
        cmd.count  = n;
        cmd.status = in_last;
        cmd_push   = accept && ((n != '0) || in_last);

        if (accept)
        begin
            mode_next = m;
            held_next = h;
        end
        else
        begin
            mode_next = mode_reg;
            held_next = held_reg;
        end
    end

endmodule

[hdl/pesc_queue.sv]
// Short command queue between the front end and the back end.
module pesc_queue
    import pesc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic head_valid,
    output logic full
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign head_valid = (fill_reg != '0);
    assign full       = (fill_reg == FILL_W'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hdl/pesc_back.sv]
// Back end: applies the byte limit, counts bytes and drives the output register.
module pesc_back
    import pesc_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        head_cmd,
    input  logic        head_valid,
    output logic        pop,
    input  logic [15:0] out_limit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        run_last,
    output logic        stream_done,
    output logic [15:0] total_length
);

    localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [LW-1:0] CMAX = LW'({COUNT_BITS{1'b1}});

    logic [COUNT_BITS-1:0] bw_reg;
    logic [COUNT_BITS-1:0] bw_next;
    logic [CMD_CNT_W-1:0]  idx_reg;
    logic [CMD_CNT_W-1:0]  idx_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic [7:0]            byte_reg;
    logic                  bvalid_reg;
    logic                  last_reg;
    logic                  done_reg;
    logic [15:0]           total_reg;

    logic [LW-1:0]         lim_w;
    logic [LW-1:0]         bw_w;
    logic [LW-1:0]         bw_inc_w;
    logic                  load;
    logic                  data_go;
    logic                  status_go;
    logic                  data_last;

    assign lim_w     = (LW'(out_limit) > CMAX) ? CMAX : LW'(out_limit);
    assign bw_w      = LW'(bw_reg);
    assign bw_inc_w  = bw_w + 1'b1;
    assign load      = !valid_reg || !out_stall;
    assign data_go   = head_valid && (idx_reg < head_cmd.count) && (bw_w < lim_w);
    assign status_go = head_valid && !data_go && head_cmd.status;
    assign data_last = ((idx_reg + 1'b1) == head_cmd.count) || (bw_inc_w >= lim_w);

    always_comb
    begin
        pop        = 1'b0;
        bw_next    = bw_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg && out_stall;
        if (head_valid && !data_go && !head_cmd.status)
        begin
            pop      = 1'b1;
            idx_next = '0;
        end
        else if (load && data_go)
        begin
            valid_next = 1'b1;
            bw_next    = bw_reg + 1'b1;
            if (data_last && !head_cmd.status)
            begin
                pop      = 1'b1;
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        else if (load && status_go)
        begin
            valid_next = 1'b1;
            pop        = 1'b1;
            idx_next   = '0;
            bw_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg    <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            bw_reg    <= bw_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && data_go)
        begin
            byte_reg   <= head_cmd.bytes[idx_reg[1:0]];
            bvalid_reg <= 1'b1;
            last_reg   <= data_last && !head_cmd.status;
            done_reg   <= 1'b0;
            total_reg  <= bw_inc_w[15:0];
        end
        else if (load && status_go)
        begin
            byte_reg   <= 8'd0;
            bvalid_reg <= 1'b0;
            last_reg   <= 1'b1;
            done_reg   <= 1'b1;
            total_reg  <= bw_w[15:0];
        end
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign byte_valid   = bvalid_reg;
    assign run_last     = last_reg;
    assign stream_done  = done_reg;
    assign total_length = total_reg;

endmodule

[hdl/printable_escape_encoder_unit.sv]
// Printable escape encoder top level: configuration registers, front end, queue and back end.
// The block takes one source byte per cycle while the queue is not full and emits printable ASCII, one
// result per cycle while the output is not stalled. Control bytes, bytes 0x7F and above, and tab, line
// feed or carriage return when enabled leave as a backslash and two uppercase hex digits; a backslash,
// dots and a hex pair gain one extra dot. An input item yields zero to five results: the front end
// classifies an item in the cycle it is accepted, a two-entry queue holds the work, and the back end
// sends one result per cycle through the output register while the output is not stalled. An item
// whose results are all dropped by the byte limit is still popped by the back end. Input is stalled
// only while the queue is full, so the sustained input rate is one item per cycle as long as each item
// yields at most one result and the output is not stalled; otherwise it follows the result count per item.
module printable_escape_encoder_unit
    import pesc_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_byte,
    output logic                  byte_valid,
    output logic                  run_last,
    output logic                  stream_done,
    output logic [15:0]           total_length,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    esc_cfg_t    esc_reg;
    logic [15:0] limit_reg;
    logic        accept;
    cmd_t        front_cmd;
    logic        front_push;
    cmd_t        head_cmd;
    logic        head_valid;
    logic        queue_full;
    logic        queue_pop;

    assign cfg_ready = 1'b1;
    assign in_stall  = queue_full;
    assign accept    = in_valid && !queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg   <= '0;
            limit_reg <= 16'hFFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ESCAPE_TAB: esc_reg.tab <= cfg_data[0];
                REG_ESCAPE_LF:  esc_reg.lf  <= cfg_data[0];
                REG_ESCAPE_CR:  esc_reg.cr  <= cfg_data[0];
                REG_OUT_LIMIT:  limit_reg   <= cfg_data[15:0];
                default:        limit_reg   <= limit_reg;
            endcase
        end
    end

    pesc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .esc_cfg  (esc_reg),
        .cmd      (front_cmd),
        .cmd_push (front_push)
    );

    pesc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_cmd   (front_cmd),
        .pop        (queue_pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .full       (queue_full)
    );

    pesc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_cmd     (head_cmd),
        .head_valid   (head_valid),
        .pop          (queue_pop),
        .out_limit    (limit_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .run_last     (run_last),
        .stream_done  (stream_done),
        .total_length (total_length)
    );

endmodule
